// ----- rtl/hc74_pkg.sv -----
// ----------------------------------------------------------------------------
// hc74_pkg
// Shared types and Hamming (7,4) code functions for the byte stream codec.
// ----------------------------------------------------------------------------
package hc74_pkg;

	// Codeword positions of the four data bits, d3 down to d0.
	localparam logic [2:0] POS_D3 = 3'd7;
	localparam logic [2:0] POS_D2 = 3'd6;
	localparam logic [2:0] POS_D1 = 3'd5;
	localparam logic [2:0] POS_D0 = 3'd3;

	// Residues of the bit packers, always held in the low bits with the
	// unused upper bits at zero.
	typedef struct packed {
		logic [6:0] in_res;
		logic [2:0] in_cnt;
		logic [7:0] out_res;
		logic [2:0] out_cnt;
	} hc74_state_t;

	// All result beats caused by one input byte.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            marker;
		logic            fin;
	} hc74_bundle_t;

	function automatic logic [6:0] encode_nibble(input logic [3:0] nib);
		logic [2:0] par;
		par = (nib[3] ? POS_D3 : 3'd0) ^ (nib[2] ? POS_D2 : 3'd0)
		    ^ (nib[1] ? POS_D1 : 3'd0) ^ (nib[0] ? POS_D0 : 3'd0);
		return {nib[3], nib[2], nib[1], par[2], nib[0], par[1], par[0]};
	endfunction

	// Bit p-1 of the codeword holds position p.
	function automatic logic [3:0] decode_word(input logic [6:0] cw);
		logic [2:0] syn;
		logic [6:0] fix;
		syn = 3'd0;
		for (int p = 1; p <= 7; p++) begin
			if (cw[p-1]) begin
				syn = syn ^ 3'(p);
			end
		end
		fix = cw;
		if (syn != 3'd0) begin
			fix = cw ^ (7'd1 << (syn - 3'd1));
		end
		return {fix[6], fix[5], fix[4], fix[2]};
	endfunction

endpackage

// ----- rtl/hc74_step.sv -----
// ----------------------------------------------------------------------------
// hc74_step
// Combinational work for one input byte: encodes or decodes it, packs the
// bits into result bytes and computes the next packer residues.
// ----------------------------------------------------------------------------
module hc74_step import hc74_pkg::*; (
	input  logic         direction,
	input  logic [7:0]   data_byte,
	input  logic         final_byte,
	input  hc74_state_t  state_cur,
	output hc74_state_t  state_nxt,
	output hc74_bundle_t bundle
);

	// Encode path: 14 code bits appended to the output residue.
	logic [13:0] enc_bits;
	logic [21:0] enc_acc;
	logic [4:0]  enc_n;
	logic [7:0]  enc_b0;
	logic [7:0]  enc_b1;
	logic [2:0]  enc_r;
	logic [7:0]  enc_res;
	logic [7:0]  enc_pad;
	logic        enc_pad_en;

	// Decode path: one or two codewords gathered across byte boundaries.
	logic [14:0] dec_acc;
	logic [3:0]  dec_n;
	logic        dec_two;
	logic [6:0]  dec_cw0;
	logic [3:0]  dec_nib0;
	logic [3:0]  dec_nib1;
	logic [2:0]  dec_rn;
	logic [6:0]  dec_in_res;
	logic [15:0] dec_oacc;
	logic [3:0]  dec_on;
	logic [7:0]  dec_byte;
	logic [7:0]  dec_out_res;

	assign enc_bits   = {encode_nibble(data_byte[7:4]), encode_nibble(data_byte[3:0])};
	assign enc_acc    = {state_cur.out_res, enc_bits};
	assign enc_n      = 5'd14 + {2'b00, state_cur.out_cnt};
	assign enc_b0     = 8'(enc_acc >> (enc_n - 5'd8));
	assign enc_b1     = 8'(enc_acc >> (enc_n - 5'd16));
	assign enc_r      = enc_n[2:0];
	assign enc_res    = enc_acc[7:0] & 8'((9'd1 << enc_r) - 9'd1);
	assign enc_pad    = 8'(enc_res << (4'd8 - {1'b0, enc_r}));
	assign enc_pad_en = final_byte && (enc_r != 3'd0);

	assign dec_acc    = {state_cur.in_res, data_byte};
	assign dec_n      = 4'd8 + {1'b0, state_cur.in_cnt};
	assign dec_two    = (dec_n == 4'd14);
	assign dec_cw0    = 7'(dec_acc >> (dec_n - 4'd7));
	assign dec_nib0   = decode_word(dec_cw0);
	assign dec_nib1   = decode_word(dec_acc[6:0]);
	assign dec_rn     = dec_two ? 3'd0 : 3'(dec_n - 4'd7);
	assign dec_in_res = dec_acc[6:0] & 7'((8'd1 << dec_rn) - 8'd1);
	assign dec_oacc   = dec_two ? {state_cur.out_res, dec_nib0, dec_nib1}
	                            : {4'b0000, state_cur.out_res, dec_nib0};
	assign dec_on     = {1'b0, state_cur.out_cnt} + (dec_two ? 4'd8 : 4'd4);
	assign dec_byte   = 8'(dec_oacc >> (dec_on - 4'd8));
	assign dec_out_res = dec_oacc[7:0] & 8'((9'd1 << dec_on[2:0]) - 9'd1);

	always_comb begin
		bundle.bytes  = '0;
		bundle.cnt    = 2'd0;
		bundle.marker = 1'b0;
		bundle.fin    = final_byte;
		state_nxt     = state_cur;
		if (!direction) begin
			bundle.bytes[0] = enc_b0;
			bundle.bytes[1] = enc_n[4] ? enc_b1 : enc_pad;
			bundle.bytes[2] = enc_pad;
			bundle.cnt      = (enc_n[4] ? 2'd2 : 2'd1) + {1'b0, enc_pad_en};
			state_nxt.out_res = enc_res;
			state_nxt.out_cnt = enc_r;
		end else begin
			bundle.bytes[0] = dec_byte;
			bundle.cnt      = {1'b0, dec_on[3]};
			state_nxt.in_res  = dec_in_res;
			state_nxt.in_cnt  = dec_rn;
			state_nxt.out_res = dec_out_res;
			state_nxt.out_cnt = dec_on[2:0];
		end
		// A final byte that yields no data still closes the stream with one beat.
		if (final_byte && (bundle.cnt == 2'd0)) begin
			bundle.cnt    = 2'd1;
			bundle.marker = 1'b1;
			bundle.bytes  = '0;
		end
		if (final_byte) begin
			state_nxt = '0;
		end
	end

endmodule

// ----- rtl/hc74_drain.sv -----
// ----------------------------------------------------------------------------
// hc74_drain
// Result register: holds the beats of one input byte and hands them out one
// per cycle while out_ready is high, flagging the last beat of byte and stream.
// ----------------------------------------------------------------------------
module hc74_drain import hc74_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  hc74_bundle_t bundle,
	output logic         free,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_byte,
	output logic         byte_valid,
	output logic         run_end,
	output logic         stream_end
);

	hc74_bundle_t bundle_s2;
	logic         valid_s2;
	logic [1:0]   idx_q;
	logic         last;
	logic         take;

	assign last       = (idx_q == (bundle_s2.cnt - 2'd1));
	assign take       = valid_s2 && out_ready;
	assign free       = !valid_s2 || (take && last);
	assign out_valid  = valid_s2;
	assign out_byte   = bundle_s2.bytes[idx_q];
	assign byte_valid = !bundle_s2.marker;
	assign run_end    = last;
	assign stream_end = last && bundle_s2.fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (free) begin
			valid_s2 <= load;
			idx_q    <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			bundle_s2 <= bundle;
		end
	end

endmodule

// ----- rtl/hamming74_byte_stream_codec_core.sv -----
// ----------------------------------------------------------------------------
// hamming74_byte_stream_codec_core
// Hamming (7,4) byte stream encoder and single-error-correcting decoder.
// ----------------------------------------------------------------------------
// Timing: an accepted byte passes the input register, then the result register,
// before its first result beat is presented; it waits in the input register
// while the result register is busy. One result beat per cycle while out_ready
// is high; a byte gives one to three beats when encoding and at most one when
// decoding, and a new byte can be taken while the beats of the last one drain.
// Reset: direction returns to encode and all packer residues are cleared.
module hamming74_byte_stream_codec_core import hc74_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_end,
	output logic       stream_end
);

	logic         direction_q;
	hc74_state_t  state_q;
	hc74_state_t  state_nxt;
	hc74_bundle_t bundle;
	logic         valid_s1;
	logic [7:0]   data_byte_s1;
	logic         final_byte_s1;
	logic         drain_free;
	logic         adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && drain_free;
	assign in_ready  = !valid_s1 || adv_s1;

	hc74_step u_step (
		.direction  (direction_q),
		.data_byte  (data_byte_s1),
		.final_byte (final_byte_s1),
		.state_cur  (state_q),
		.state_nxt  (state_nxt),
		.bundle     (bundle)
	);

	hc74_drain u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv_s1 && (bundle.cnt != 2'd0)),
		.bundle     (bundle),
		.free       (drain_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			direction_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			// A direction change starts a fresh stream.
			if (cfg_valid && cfg_ready) begin
				direction_q <= cfg_data;
				state_q     <= '0;
			end else if (adv_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1  <= data_byte;
			final_byte_s1 <= final_byte;
		end
	end

	// Decoding packs whole nibbles, so the output residue is empty or half a byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		direction_q |-> (state_q.out_cnt == 3'd0 || state_q.out_cnt == 3'd4))
		else $error("decode output residue is not nibble aligned");

	// Encoding never gathers codeword bits on the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		!direction_q |-> (state_q.in_cnt == 3'd0 && state_q.in_res == 7'd0))
		else $error("input residue holds bits while encoding");

	// Seven gathered bits always form a codeword at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.in_cnt != 3'd7)
		else $error("input residue reached a full codeword");

	// The end of a stream is also the end of the beats of its last byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stream_end) |-> run_end)
		else $error("stream end beat is not the last beat of its byte");

	// A stalled result beat stays offered with its payload unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable({out_byte, byte_valid, run_end, stream_end})))
		else $error("result beat changed while stalled");

endmodule

// ----- bench/tb_hamming74_byte_stream_codec_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming74_byte_stream_codec_core
// Drives byte streams through the Hamming (7,4) codec in both directions and
// checks every output beat against a bit-level prediction of the packers.
// ----------------------------------------------------------------------------
module tb_hamming74_byte_stream_codec_core;

	typedef struct packed {
		logic [7:0] value;
		logic       has_data;
		logic       item_end;
		logic       stream_done;
	} codec_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'd0;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_end;
	logic       stream_end;

	hamming74_byte_stream_codec_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Predicted codec state.
	logic        dir_decode = 1'b0;
	logic [6:0]  cw_hold = 7'd0;
	int          cw_bits = 0;
	logic [7:0]  byte_hold = 8'd0;
	int          byte_bits = 0;
	codec_beat_t expected_beats[$];
	int          mismatch_count = 0;
	int          burst_left = 0;

	function automatic logic [6:0] hamming_encode(input logic [3:0] d);
		logic p1, p2, p4;
		// Data sits at positions 7, 6, 5 and 3; each parity bit covers the
		// positions whose index has that bit set.
		p1 = d[3] ^ d[1] ^ d[0];
		p2 = d[3] ^ d[2] ^ d[0];
		p4 = d[3] ^ d[2] ^ d[1];
		return {d[3], d[2], d[1], p4, d[0], p2, p1};
	endfunction

	function automatic logic [3:0] hamming_correct(input logic [6:0] cw);
		logic [2:0] syn;
		logic [6:0] fixed;
		syn[0] = cw[0] ^ cw[2] ^ cw[4] ^ cw[6];
		syn[1] = cw[1] ^ cw[2] ^ cw[5] ^ cw[6];
		syn[2] = cw[3] ^ cw[4] ^ cw[5] ^ cw[6];
		fixed = cw;
		if (syn != 3'd0) begin
			fixed[syn - 3'd1] = ~cw[syn - 3'd1];
		end
		return {fixed[6], fixed[5], fixed[4], fixed[2]};
	endfunction

	task automatic clear_packers();
		cw_hold = 7'd0;
		cw_bits = 0;
		byte_hold = 8'd0;
		byte_bits = 0;
	endtask

	// Adds one predicted beat to the tail of the queue.
	task automatic add_beat(input logic [7:0] value, input logic has_data);
		codec_beat_t beat;
		beat = '{value, has_data, 1'b0, 1'b0};
		expected_beats.insert(expected_beats.size(), beat);
	endtask

	// Appends bits to the output byte packer; at most one byte fills per call.
	task automatic pack_bits(input logic [6:0] bits, input int nbits);
		logic [14:0] acc;
		logic [14:0] top;
		acc = ({7'd0, byte_hold} << nbits) | {8'd0, bits};
		byte_bits = byte_bits + nbits;
		if (byte_bits >= 8) begin
			byte_bits = byte_bits - 8;
			top = acc >> byte_bits;
			add_beat(top[7:0], 1'b1);
		end
		acc = acc & ((15'd1 << byte_bits) - 15'd1);
		byte_hold = acc[7:0];
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic fin);
		logic [14:0] acc;
		logic [6:0]  cw;
		int          n;
		int          first;
		codec_beat_t tail;
		first = expected_beats.size();
		if (!dir_decode) begin
			pack_bits(hamming_encode(b[7:4]), 7);
			pack_bits(hamming_encode(b[3:0]), 7);
			if (fin && byte_bits != 0) begin
				add_beat(8'(byte_hold << (8 - byte_bits)), 1'b1);
			end
		end else begin
			acc = ({8'd0, cw_hold} << 8) | {7'd0, b};
			n = cw_bits + 8;
			while (n >= 7) begin
				n = n - 7;
				cw = 7'(acc >> n);
				pack_bits({3'd0, hamming_correct(cw)}, 4);
			end
			acc = acc & ((15'd1 << n) - 15'd1);
			cw_hold = acc[6:0];
			cw_bits = n;
		end
		// A final byte that fills no output byte still closes the stream.
		if (expected_beats.size() == first && fin) begin
			add_beat(8'd0, 1'b0);
		end
		if (expected_beats.size() != first) begin
			tail = expected_beats[expected_beats.size() - 1];
			tail.item_end = 1'b1;
			tail.stream_done = fin;
			expected_beats[expected_beats.size() - 1] = tail;
		end
		if (fin) begin
			clear_packers();
		end
	endtask

	task automatic log_mismatch(input string what, input codec_beat_t want,
	                            input codec_beat_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("MISMATCH %s: expected byte=%02h valid=%0b run_end=%0b stream_end=%0b,",
			         what, want.value, want.has_data, want.item_end, want.stream_done);
			$display("  got byte=%02h valid=%0b run_end=%0b stream_end=%0b",
			         got.value, got.has_data, got.item_end, got.stream_done);
		end
	endtask

	// Output side: check each accepted beat and stall on a rotating mask.
	int unsigned ready_tick = 0;
	logic [15:0] ready_mask = 16'hFFFF;

	always @(posedge clk) begin
		codec_beat_t want;
		codec_beat_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{out_byte, byte_valid, run_end, stream_end};
			if (expected_beats.size() == 0) begin
				log_mismatch("unexpected beat", '0, got);
			end else begin
				want = expected_beats.pop_front();
				if (got.value !== want.value || got.has_data !== want.has_data ||
				    got.item_end !== want.item_end || got.stream_done !== want.stream_done) begin
					log_mismatch("wrong beat", want, got);
				end
			end
		end
		if (ready_tick % 64 == 0) begin
			ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		end
		out_ready <= ready_mask[ready_tick % 16];
		ready_tick++;
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		predict_byte(b, fin);
	endtask

	task automatic write_direction(input logic d);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dir_decode = d;
		clear_packers();
	endtask

	// Bytes that fill no output byte can still be in flight once the queue
	// empties, so the task waits on after that before the block counts as idle.
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_encode_extremes();
		write_direction(1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFE, 1'b1);
		drain_results();
	endtask

	task automatic test_decode_cases();
		write_direction(1'b1);
		// A lone final byte holds only one codeword, so only an end marker comes out.
		send_byte(8'h3C, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b1);
		drain_results();
	endtask

	task automatic test_direction_clears();
		write_direction(1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		drain_results();
		write_direction(1'b1);
		send_byte(8'h56, 1'b0);
		send_byte(8'h78, 1'b1);
		drain_results();
		write_direction(1'b0);
		send_byte(8'h9A, 1'b0);
		drain_results();
		write_direction(1'b0);
		send_byte(8'hBC, 1'b1);
		drain_results();
	endtask

	// Every 7-bit word is within one bit of a codeword, so random bytes are
	// well-formed decode input; some streams are left open across a write.
	task automatic test_random_streams();
		int sent;
		int len;
		logic fin;
		for (int ph = 0; ph < 6; ph++) begin
			write_direction(ph % 2 == 1);
			sent = 0;
			while (sent < 30) begin
				len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					fin = (k == len - 1) && ($urandom_range(0, 7) != 0);
					send_byte(8'($urandom), fin);
					sent++;
				end
			end
			drain_results();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_extremes();
		test_decode_cases();
		test_direction_clears();
		test_random_streams();
		if (expected_beats.size() != 0) begin
			log_mismatch("missing beat", expected_beats[0], '0);
		end
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
